// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// The expression holds at every clock edge out of reset.
`define AST_ALWAYS(lbl, expr) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error("assertion failed");
// When the antecedent holds, the consequent holds in the next cycle.
`define AST_IMPLY_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define AST_ALWAYS(lbl, expr)
`define AST_IMPLY_NEXT(lbl, ante, cons)
`endif
`endif

// ===== hw/rtl/pap_pkg.sv =====
// ----------------------------------------------------------------------------
// pap_pkg
// Sizes, codes and beat types of the power-of-two page allocator.
// ----------------------------------------------------------------------------
package pap_pkg;

	localparam int NUM_PAGES  = 4096;
	localparam int NUM_LEVELS = 11;
	localparam int PAGE_BITS  = 12;

	localparam int PAGE_W  = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;
	localparam int CNT_W   = $clog2(NUM_PAGES + 1);
	localparam int LVL_W   = $clog2(NUM_LEVELS + 1);
	localparam int LIDX_W  = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;
	localparam int ALIGN_W = 4;
	localparam int OFF_W   = (1 << ALIGN_W) - 1;
	localparam int ADDR_W  = 32;

	localparam logic       FUNC_ALLOC  = 1'b0;
	localparam logic       FUNC_FREE   = 1'b1;
	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_NO_SPACE = 2'd1;
	localparam logic [1:0] ST_BAD      = 2'd2;

	typedef struct packed {
		logic              func;
		logic [12:0]       page_count;
		logic [ALIGN_W-1:0] align_log2;
		logic [11:0]       page_index;
	} in_beat_t;

	typedef struct packed {
		logic [1:0]        status;
		logic [11:0]       first_page;
		logic [ADDR_W-1:0] phys_address;
		logic [12:0]       free_total;
	} out_beat_t;

endpackage

// ===== hw/rtl/pap_ram.sv =====
// ----------------------------------------------------------------------------
// pap_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module pap_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                     clk,
	input  logic                                     we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                         wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ===== hw/rtl/power_of_two_page_allocator_core.sv =====
// ----------------------------------------------------------------------------
// power_of_two_page_allocator_core
// A free splits its range into one block per set binary digit of its length,
// lowest first, and then a run of top-level blocks; an allocate scans the
// start map one entry a cycle between found blocks, per nonempty level, and
// on failure runs one merge pass and a second search.
// One request is in flight at a time; the start map RAM port sets the rate.
// Reset: a clearing pass over every map entry, then the initial split of the
// whole region, before in_ready rises. Configuration is taken at any time.
// ----------------------------------------------------------------------------
module power_of_two_page_allocator_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  pap_pkg::in_beat_t   in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output pap_pkg::out_beat_t  out_data,
	input  logic                cfg_we,
	input  logic [31:0]         cfg_wdata
);
	import pap_pkg::*;
	`include "assert_macros.svh"

	// Sequencer states.
	localparam logic [3:0] S_CLR   = 4'd0;  // clearing pass after reset
	localparam logic [3:0] S_IDLE  = 4'd1;
	localparam logic [3:0] S_LVL   = 4'd2;  // pick next level to search
	localparam logic [3:0] S_SCAN  = 4'd3;  // stream through the start map
	localparam logic [3:0] S_FIT   = 4'd4;  // compute alignment offset
	localparam logic [3:0] S_CHK   = 4'd5;  // does the request fit the block
	localparam logic [3:0] S_TAKE  = 4'd6;
	localparam logic [3:0] S_HEAD  = 4'd7;
	localparam logic [3:0] S_PSTEP = 4'd8;  // one step of range splitting
	localparam logic [3:0] S_RMW   = 4'd9;  // write back a modified entry
	localparam logic [3:0] S_MLVL  = 4'd10; // merge: pick next level
	localparam logic [3:0] S_MRG2  = 4'd11; // merge: fold lower block upward
	localparam logic [3:0] S_MRES  = 4'd12; // merge: resume scan
	localparam logic [3:0] S_FIN   = 4'd13;

	// Which range the splitter is working on.
	localparam logic [1:0] PUT_INIT = 2'd0;
	localparam logic [1:0] PUT_HEAD = 2'd1;
	localparam logic [1:0] PUT_TAIL = 2'd2;
	localparam logic [1:0] PUT_FREE = 2'd3;

	localparam int PG_W = CNT_W + 1;

	logic [3:0]            state_q;
	logic [PAGE_W-1:0]     clr_q;
	logic [31:0]           base_q;
	in_beat_t              req_q;
	logic [OFF_W-1:0]      nb_q;
	logic [LVL_W-1:0]      lvl_q;
	logic                  merge_q;
	logic                  try_q;
	logic [CNT_W-1:0]      scan_addr_q;
	logic                  chk_vld_q;
	logic [PAGE_W-1:0]     chk_addr_q;
	logic [PAGE_W-1:0]     cur_q;
	logic [PAGE_W-1:0]     nxt_q;
	logic                  have_q;
	logic [OFF_W-1:0]      off_q;
	logic [PG_W-1:0]       pg_q;
	logic [CNT_W-1:0]      len_q;
	logic [CNT_W-1:0]      tcnt_q;
	logic [LVL_W-1:0]      plvl_q;
	logic [1:0]            psel_q;
	logic [PAGE_W-1:0]     rmw_addr_q;
	logic                  rmw_clr_q;
	logic                  rmw_set_q;
	logic [LIDX_W-1:0]     rmw_clr_lvl_q;
	logic [LIDX_W-1:0]     rmw_set_lvl_q;
	logic [3:0]            rmw_ret_q;
	logic [CNT_W-1:0]      lcnt_q [NUM_LEVELS];
	logic [CNT_W-1:0]      fp_q;
	logic [1:0]            st_q;
	logic [PAGE_W-1:0]     first_q;
	logic                  out_vld_q;
	out_beat_t             out_q;

	logic                  ram_we;
	logic [PAGE_W-1:0]     ram_waddr;
	logic [NUM_LEVELS-1:0] ram_wdata;
	logic [PAGE_W-1:0]     rd_addr_c;
	logic [NUM_LEVELS-1:0] rd_data;

	logic [LIDX_W-1:0]     lidx;
	logic [CNT_W-1:0]      bsize;
	logic [CNT_W-1:0]      lcnt_cur;
	logic                  hit_c;
	logic                  adj_c;
	logic [CNT_W-1:0]      len_sh;
	logic [OFF_W-1:0]      align_mask;
	logic [OFF_W:0]        need;
	logic [CNT_W-1:0]      fp_next;
	logic [CNT_W:0]        fp_sum;
	logic [CNT_W:0]        free_end;
	logic [NUM_LEVELS-1:0] clr_mask;
	logic [NUM_LEVELS-1:0] set_mask;
	logic                  clr_hit;
	logic                  set_hit;
	logic [31:0]           phys_c;
	logic                  fin_load;

	pap_ram #(
		.WIDTH(NUM_LEVELS),
		.DEPTH(NUM_PAGES)
	) u_map (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(rd_addr_c),
		.rdata(rd_data)
	);

	assign lidx     = lvl_q[LIDX_W-1:0];
	assign bsize    = CNT_W'(1) << lvl_q;
	assign lcnt_cur = lcnt_q[lidx];
	// A scanned entry arrives in the cycle after its address went out.
	assign hit_c    = chk_vld_q && rd_data[lidx];
	assign adj_c    = have_q && (CNT_W'(chk_addr_q) == CNT_W'(cur_q) + bsize);
	assign len_sh   = len_q >> plvl_q;
	assign align_mask = (OFF_W'(1) << req_q.align_log2) - OFF_W'(1);
	assign need     = {1'b0, off_q} + (OFF_W + 1)'(req_q.page_count);
	assign free_end = (CNT_W + 1)'(in_data.page_index) + (CNT_W + 1)'(in_data.page_count);
	assign fp_sum   = {1'b0, fp_q} + {1'b0, req_q.page_count};

	assign clr_mask = rmw_clr_q ? (NUM_LEVELS'(1) << rmw_clr_lvl_q) : '0;
	assign set_mask = rmw_set_q ? (NUM_LEVELS'(1) << rmw_set_lvl_q) : '0;
	assign clr_hit  = rmw_clr_q && rd_data[rmw_clr_lvl_q];
	assign set_hit  = rmw_set_q && !rd_data[rmw_set_lvl_q];

	// The result register takes a beat when it is empty or being drained.
	assign fin_load = (state_q == S_FIN) && (!out_vld_q || out_ready);

	// Free count after the request; saturates at both ends.
	always_comb begin
		fp_next = fp_q;
		if (st_q == ST_OK) begin
			if (req_q.func == FUNC_ALLOC) begin
				fp_next = (fp_q >= req_q.page_count) ? fp_q - req_q.page_count : '0;
			end else if (fp_sum > (CNT_W + 1)'(NUM_PAGES)) begin
				fp_next = CNT_W'(NUM_PAGES);
			end else begin
				fp_next = fp_sum[CNT_W-1:0];
			end
		end
	end

	assign phys_c = {base_q[31:PAGE_BITS], {PAGE_BITS{1'b0}}}
		+ (32'(first_q) << PAGE_BITS);

	// Read address: every state that starts a read-modify-write or a scan
	// step drives the address whose data the next state consumes.
	always_comb begin
		rd_addr_c = scan_addr_q[PAGE_W-1:0];
		unique case (state_q)
			S_SCAN: begin
				if (hit_c && merge_q && adj_c) begin
					rd_addr_c = chk_addr_q;
				end
			end
			S_TAKE, S_MRG2: rd_addr_c = cur_q;
			S_PSTEP: rd_addr_c = pg_q[PAGE_W-1:0];
			default: rd_addr_c = scan_addr_q[PAGE_W-1:0];
		endcase
	end

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = rmw_addr_q;
		ram_wdata = (rd_data & ~clr_mask) | set_mask;
		if (state_q == S_CLR) begin
			ram_we    = 1'b1;
			ram_waddr = clr_q;
			ram_wdata = '0;
		end else if (state_q == S_RMW) begin
			ram_we = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= '0;
		end else if (cfg_we) begin
			base_q <= cfg_wdata;
		end
	end

	// Result valid: set when a finished request loads the register, cleared
	// when the beat is taken with nothing new behind it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (fin_load) begin
			out_vld_q <= 1'b1;
		end else if (out_ready) begin
			out_vld_q <= 1'b0;
		end
	end

	// Per-level block counts follow every map write.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_LEVELS; i++) begin
				lcnt_q[i] <= '0;
			end
		end else if (state_q == S_RMW) begin
			for (int i = 0; i < NUM_LEVELS; i++) begin
				if (clr_hit && rmw_clr_lvl_q == LIDX_W'(i)) begin
					lcnt_q[i] <= lcnt_q[i] - CNT_W'(1);
				end else if (set_hit && rmw_set_lvl_q == LIDX_W'(i)) begin
					lcnt_q[i] <= lcnt_q[i] + CNT_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_CLR;
			clr_q     <= '0;
			lvl_q     <= '0;
			merge_q   <= 1'b0;
			try_q     <= 1'b0;
			chk_vld_q <= 1'b0;
			have_q    <= 1'b0;
			psel_q    <= PUT_INIT;
			rmw_ret_q <= S_IDLE;
			fp_q      <= CNT_W'(NUM_PAGES);
		end else begin
			unique case (state_q)
				S_CLR: begin
					clr_q <= clr_q + PAGE_W'(1);
					if (clr_q == PAGE_W'(NUM_PAGES - 1)) begin
						// The whole region goes in as one range.
						pg_q    <= '0;
						len_q   <= CNT_W'(NUM_PAGES);
						tcnt_q  <= CNT_W'(NUM_PAGES) >> (NUM_LEVELS - 1);
						plvl_q  <= '0;
						psel_q  <= PUT_INIT;
						state_q <= S_PSTEP;
					end
				end
				S_IDLE: begin
					if (in_valid) begin
						req_q <= in_data;
						nb_q  <= ~base_q[PAGE_BITS +: OFF_W] + OFF_W'(1);
						if (in_data.func == FUNC_ALLOC) begin
							if (in_data.page_count == '0
								|| in_data.page_count > CNT_W'(NUM_PAGES)) begin
								st_q    <= ST_BAD;
								state_q <= S_FIN;
							end else begin
								lvl_q   <= '0;
								try_q   <= 1'b0;
								merge_q <= 1'b0;
								state_q <= S_LVL;
							end
						end else begin
							if (in_data.page_count == '0
								|| free_end > (CNT_W + 1)'(NUM_PAGES)) begin
								st_q    <= ST_BAD;
								state_q <= S_FIN;
							end else begin
								pg_q    <= PG_W'(in_data.page_index);
								len_q   <= in_data.page_count;
								tcnt_q  <= in_data.page_count >> (NUM_LEVELS - 1);
								plvl_q  <= '0;
								psel_q  <= PUT_FREE;
								first_q <= PAGE_W'(in_data.page_index);
								state_q <= S_PSTEP;
							end
						end
					end
				end
				S_LVL: begin
					if (lvl_q >= LVL_W'(NUM_LEVELS)) begin
						if (!try_q) begin
							merge_q <= 1'b1;
							lvl_q   <= '0;
							state_q <= S_MLVL;
						end else begin
							st_q    <= ST_NO_SPACE;
							state_q <= S_FIN;
						end
					end else if (req_q.page_count > bsize || lcnt_cur == '0) begin
						lvl_q <= lvl_q + LVL_W'(1);
					end else begin
						scan_addr_q <= '0;
						chk_vld_q   <= 1'b0;
						state_q     <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (hit_c) begin
						chk_vld_q <= 1'b0;
						if (!merge_q) begin
							cur_q   <= chk_addr_q;
							state_q <= S_FIT;
						end else if (adj_c) begin
							// Adjacent pair: clear the upper block first.
							nxt_q         <= chk_addr_q;
							rmw_addr_q    <= chk_addr_q;
							rmw_clr_q     <= 1'b1;
							rmw_set_q     <= 1'b0;
							rmw_clr_lvl_q <= lidx;
							rmw_set_lvl_q <= lidx;
							rmw_ret_q     <= S_MRG2;
							state_q       <= S_RMW;
						end else begin
							cur_q       <= chk_addr_q;
							have_q      <= 1'b1;
							scan_addr_q <= CNT_W'(chk_addr_q) + CNT_W'(1);
						end
					end else if (scan_addr_q < CNT_W'(NUM_PAGES)) begin
						chk_vld_q   <= 1'b1;
						chk_addr_q  <= scan_addr_q[PAGE_W-1:0];
						scan_addr_q <= scan_addr_q + CNT_W'(1);
					end else begin
						chk_vld_q <= 1'b0;
						lvl_q     <= lvl_q + LVL_W'(1);
						state_q   <= merge_q ? S_MLVL : S_LVL;
					end
				end
				S_FIT: begin
					off_q   <= (nb_q - OFF_W'(cur_q)) & align_mask;
					state_q <= S_CHK;
				end
				S_CHK: begin
					if (need <= (OFF_W + 1)'(bsize)) begin
						state_q <= S_TAKE;
					end else begin
						scan_addr_q <= CNT_W'(cur_q) + CNT_W'(1);
						chk_vld_q   <= 1'b0;
						state_q     <= S_SCAN;
					end
				end
				S_TAKE: begin
					rmw_addr_q    <= cur_q;
					rmw_clr_q     <= 1'b1;
					rmw_set_q     <= 1'b0;
					rmw_clr_lvl_q <= lidx;
					rmw_set_lvl_q <= lidx;
					rmw_ret_q     <= S_HEAD;
					state_q       <= S_RMW;
				end
				S_HEAD: begin
					pg_q    <= PG_W'(cur_q);
					len_q   <= off_q[CNT_W-1:0];
					tcnt_q  <= off_q[CNT_W-1:0] >> (NUM_LEVELS - 1);
					plvl_q  <= '0;
					psel_q  <= PUT_HEAD;
					first_q <= PAGE_W'(CNT_W'(cur_q) + off_q[CNT_W-1:0]);
					state_q <= S_PSTEP;
				end
				S_PSTEP: begin
					if (plvl_q < LVL_W'(NUM_LEVELS - 1)) begin
						plvl_q <= plvl_q + LVL_W'(1);
						if (len_sh[0]) begin
							pg_q <= pg_q + (PG_W'(1) << plvl_q);
							if (pg_q < PG_W'(NUM_PAGES)) begin
								rmw_addr_q    <= pg_q[PAGE_W-1:0];
								rmw_clr_q     <= 1'b0;
								rmw_set_q     <= 1'b1;
								rmw_clr_lvl_q <= plvl_q[LIDX_W-1:0];
								rmw_set_lvl_q <= plvl_q[LIDX_W-1:0];
								rmw_ret_q     <= S_PSTEP;
								state_q       <= S_RMW;
							end
						end
					end else if (tcnt_q != '0) begin
						// Length beyond the top level: whole top blocks in a row.
						tcnt_q <= tcnt_q - CNT_W'(1);
						pg_q   <= pg_q + (PG_W'(1) << (NUM_LEVELS - 1));
						if (pg_q < PG_W'(NUM_PAGES)) begin
							rmw_addr_q    <= pg_q[PAGE_W-1:0];
							rmw_clr_q     <= 1'b0;
							rmw_set_q     <= 1'b1;
							rmw_clr_lvl_q <= LIDX_W'(NUM_LEVELS - 1);
							rmw_set_lvl_q <= LIDX_W'(NUM_LEVELS - 1);
							rmw_ret_q     <= S_PSTEP;
							state_q       <= S_RMW;
						end
					end else begin
						unique case (psel_q)
							PUT_INIT: state_q <= S_IDLE;
							PUT_HEAD: begin
								// Tail remainder follows the allocated pages.
								pg_q <= PG_W'(cur_q) + PG_W'(off_q[CNT_W-1:0])
									+ PG_W'(req_q.page_count);
								len_q <= bsize - off_q[CNT_W-1:0] - req_q.page_count;
								tcnt_q <= (bsize - off_q[CNT_W-1:0] - req_q.page_count)
									>> (NUM_LEVELS - 1);
								plvl_q <= '0;
								psel_q <= PUT_TAIL;
							end
							PUT_TAIL, PUT_FREE: begin
								st_q    <= ST_OK;
								state_q <= S_FIN;
							end
							default: state_q <= S_IDLE;
						endcase
					end
				end
				S_RMW: begin
					state_q <= rmw_ret_q;
				end
				S_MLVL: begin
					if (lvl_q >= LVL_W'(NUM_LEVELS - 1)) begin
						// The top level never merges; retry the search.
						try_q   <= 1'b1;
						merge_q <= 1'b0;
						lvl_q   <= '0;
						state_q <= S_LVL;
					end else if (lcnt_cur < CNT_W'(2)) begin
						lvl_q <= lvl_q + LVL_W'(1);
					end else begin
						scan_addr_q <= '0;
						chk_vld_q   <= 1'b0;
						have_q      <= 1'b0;
						state_q     <= S_SCAN;
					end
				end
				S_MRG2: begin
					rmw_addr_q    <= cur_q;
					rmw_clr_q     <= 1'b1;
					rmw_set_q     <= 1'b1;
					rmw_clr_lvl_q <= lidx;
					rmw_set_lvl_q <= lidx + LIDX_W'(1);
					rmw_ret_q     <= S_MRES;
					state_q       <= S_RMW;
				end
				S_MRES: begin
					scan_addr_q <= CNT_W'(nxt_q) + CNT_W'(1);
					chk_vld_q   <= 1'b0;
					have_q      <= 1'b0;
					state_q     <= S_SCAN;
				end
				S_FIN: begin
					if (fin_load) begin
						out_q.status       <= st_q;
						out_q.first_page   <= (st_q == ST_OK) ? 12'(first_q) : '0;
						out_q.phys_address <= (st_q == ST_OK) ? phys_c : '0;
						out_q.free_total   <= fp_next;
						fp_q               <= fp_next;
						state_q            <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_vld_q;
	assign out_data  = out_q;

	`AST_ALWAYS(a_free_bound, fp_q <= CNT_W'(NUM_PAGES))
	`AST_ALWAYS(a_rmw_read_addr, (state_q != S_RMW) || (rmw_addr_q == $past(rd_addr_c)))
	`AST_IMPLY_NEXT(a_accept_busy, in_valid && in_ready, state_q != S_IDLE)
	`AST_IMPLY_NEXT(a_fin_loads, (state_q == S_FIN) && (!out_valid || out_ready), out_valid)
endmodule

// ===== tb/power_of_two_page_allocator_checker.sv =====
// ----------------------------------------------------------------------------
// power_of_two_page_allocator_checker
// Watches both channels of the allocator, predicts every result beat from its
// own copy of the free levels, and compares each accepted result beat.
// ----------------------------------------------------------------------------
module power_of_two_page_allocator_checker
	import pap_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	input  logic      in_ready,
	input  in_beat_t  in_data,
	input  logic      out_valid,
	input  logic      out_ready,
	input  out_beat_t out_data,
	input  logic      cfg_we,
	input  logic [31:0] cfg_wdata,
	output int        fail_count,
	output int        pending
);

	logic [NUM_LEVELS-1:0] start_map [NUM_PAGES];
	int unsigned           lvl_count [NUM_LEVELS];
	int unsigned           pages_free;
	logic [31:0]           base_reg;
	out_beat_t             expected_q [$];

	function automatic void add_block(int unsigned page, int lvl);
		if (page >= NUM_PAGES) return;
		if (!start_map[page][lvl]) begin
			start_map[page][lvl] = 1'b1;
			lvl_count[lvl]++;
		end
	endfunction

	function automatic void remove_block(int unsigned page, int lvl);
		if (page >= NUM_PAGES) return;
		if (start_map[page][lvl]) begin
			start_map[page][lvl] = 1'b0;
			lvl_count[lvl]--;
		end
	endfunction

	// Splits a range by its binary digits, lowest first; any length above the
	// top level becomes a run of top-level blocks placed last.
	function automatic void release_range(int unsigned page, int unsigned len);
		for (int lvl = 0; lvl < NUM_LEVELS - 1; lvl++) begin
			if ((len >> lvl) & 1) begin
				add_block(page, lvl);
				page += 1 << lvl;
			end
		end
		len >>= (NUM_LEVELS - 1);
		while (len > 0) begin
			add_block(page, NUM_LEVELS - 1);
			page += 1 << (NUM_LEVELS - 1);
			len--;
		end
	endfunction

	function automatic int first_start_from(int unsigned from, int lvl);
		for (int unsigned p = from; p < NUM_PAGES; p++)
			if (start_map[p][lvl]) return p;
		return -1;
	endfunction

	// One pass joins neighbors of equal size, aligned or not, below the top.
	function automatic void coalesce_levels();
		int cur;
		int nxt;
		for (int lvl = 0; lvl < NUM_LEVELS - 1; lvl++) begin
			cur = first_start_from(0, lvl);
			while (cur >= 0) begin
				nxt = first_start_from(cur + 1, lvl);
				if (nxt < 0) break;
				if (nxt == cur + (1 << lvl)) begin
					remove_block(cur, lvl);
					remove_block(nxt, lvl);
					add_block(cur, lvl + 1);
					cur = first_start_from(nxt + 1, lvl);
				end else begin
					cur = nxt;
				end
			end
		end
	endfunction

	function automatic bit find_fit(int unsigned size, int unsigned align,
			output int unsigned first);
		longint unsigned base_page;
		longint unsigned al;
		longint unsigned abs_page;
		longint unsigned up;
		longint unsigned off;
		int unsigned     bsize;
		int              cur;
		base_page = base_reg >> PAGE_BITS;
		al = 64'd1 << align;
		first = 0;
		for (int lvl = 0; lvl < NUM_LEVELS; lvl++) begin
			bsize = 1 << lvl;
			if (size > bsize) continue;
			for (cur = first_start_from(0, lvl); cur >= 0;
					cur = first_start_from(cur + 1, lvl)) begin
				abs_page = base_page + cur;
				up = (abs_page + al - 1) & ~(al - 1);
				off = up - abs_page;
				if (off + size > bsize) continue;
				remove_block(cur, lvl);
				release_range(cur, off);
				release_range(cur + off + size, bsize - off - size);
				first = cur + off;
				return 1'b1;
			end
		end
		return 1'b0;
	endfunction

	function automatic out_beat_t predict_result(in_beat_t req);
		out_beat_t   res;
		int unsigned cnt;
		int unsigned first;
		bit          ok;
		cnt = req.page_count;
		first = 0;
		res.status = ST_OK;
		if (req.func == FUNC_ALLOC) begin
			if (cnt == 0 || cnt > NUM_PAGES) begin
				res.status = ST_BAD;
			end else begin
				ok = find_fit(cnt, req.align_log2, first);
				if (!ok) begin
					coalesce_levels();
					ok = find_fit(cnt, req.align_log2, first);
				end
				if (ok) pages_free = (pages_free >= cnt) ? pages_free - cnt : 0;
				else res.status = ST_NO_SPACE;
			end
		end else begin
			if (cnt == 0 || req.page_index + cnt > NUM_PAGES) begin
				res.status = ST_BAD;
			end else begin
				release_range(req.page_index, cnt);
				pages_free += cnt;
				if (pages_free > NUM_PAGES) pages_free = NUM_PAGES;
				first = req.page_index;
			end
		end
		if (res.status != ST_OK) first = 0;
		res.first_page = first[11:0];
		res.phys_address = (res.status == ST_OK) ?
			{base_reg[31:PAGE_BITS], {PAGE_BITS{1'b0}}} + (first << PAGE_BITS) : '0;
		res.free_total = pages_free[12:0];
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		out_beat_t e;
		if (!arst_n) begin
			for (int p = 0; p < NUM_PAGES; p++) start_map[p] = '0;
			for (int l = 0; l < NUM_LEVELS; l++) lvl_count[l] = 0;
			base_reg = '0;
			release_range(0, NUM_PAGES);
			pages_free = NUM_PAGES;
			expected_q.delete();
			fail_count = 0;
			pending = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_q.size() == 0) begin
					$display("%0t: result beat with nothing expected, actual %p", $time, out_data);
					fail_count++;
				end else begin
					e = expected_q.pop_front();
					if (out_data.status !== e.status) begin
						$display("%0t: status expected %0d actual %0d",
							$time, e.status, out_data.status);
						fail_count++;
					end
					if (out_data.first_page !== e.first_page) begin
						$display("%0t: first_page expected %0d actual %0d",
							$time, e.first_page, out_data.first_page);
						fail_count++;
					end
					if (out_data.phys_address !== e.phys_address) begin
						$display("%0t: phys_address expected %h actual %h",
							$time, e.phys_address, out_data.phys_address);
						fail_count++;
					end
					if (out_data.free_total !== e.free_total) begin
						$display("%0t: free_total expected %0d actual %0d",
							$time, e.free_total, out_data.free_total);
						fail_count++;
					end
				end
			end
			if (cfg_we) base_reg = cfg_wdata;
			if (in_valid && in_ready) expected_q.push_back(predict_result(in_data));
			pending = expected_q.size();
		end
	end

endmodule

// ===== tb/tb_power_of_two_page_allocator_core.sv =====
// ----------------------------------------------------------------------------
// tb_power_of_two_page_allocator_core
// Drives allocate and free requests into the page allocator under several
// region bases, with bursty input and a stalling output; a checker beside
// the block predicts and compares every result beat.
// ----------------------------------------------------------------------------
module tb_power_of_two_page_allocator_core;
	import pap_pkg::*;

	// Cycles without any accepted beat before the run is declared hung. The
	// worst request scans every level twice around a merge pass, and the long
	// output hold-off comes on top of that.
	localparam int IDLE_LIMIT = 4000000;
	localparam int NUM_PHASES = 5;
	localparam int RAND_PER_PHASE = 112;
	localparam int HOLD_CYCLES = 3000;

	logic      clk;
	logic      arst_n;
	logic      in_valid;
	logic      in_ready;
	in_beat_t  in_data;
	logic      out_valid;
	logic      out_ready;
	out_beat_t out_data;
	logic      cfg_we;
	logic [31:0] cfg_wdata;
	int        fail_count;
	int        pending;

	// Allocations the block has granted and not yet given back; frees of these
	// make up the well-formed part of the traffic.
	int unsigned live_first [$];
	int unsigned live_cnt [$];
	in_beat_t    issued_q [$];
	bit          hold_req;
	int          idle_cycles;

	power_of_two_page_allocator_core uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	power_of_two_page_allocator_checker checker_i (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_data    (in_data),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_data   (out_data),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.fail_count (fail_count),
		.pending    (pending)
	);

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	// Track which requests were granted so that later frees can return them.
	always @(posedge clk) begin
		in_beat_t req;
		if (arst_n) begin
			if (in_valid && in_ready) issued_q.push_back(in_data);
			if (out_valid && out_ready && issued_q.size() > 0) begin
				req = issued_q.pop_front();
				if (req.func == FUNC_ALLOC && out_data.status == ST_OK) begin
					live_first.push_back(out_data.first_page);
					live_cnt.push_back(req.page_count);
				end
			end
		end
	end

	// Watchdog: any accepted beat on either channel restarts the count.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("TB_ERROR");
				$finish;
			end
		end
	end

	// Receiver: stall modes change every so often, and a requested hold-off
	// keeps out_ready low long enough for the block to back up its input.
	initial begin
		int mode;
		int span;
		out_ready <= 1'b0;
		@(posedge clk);
		forever begin
			if (hold_req) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
			end
			mode = $urandom_range(0, 3);
			span = $urandom_range(20, 300);
			repeat (span) begin
				case (mode)
					0: begin
						out_ready <= 1'b1;
					end
					1: begin
						out_ready <= $urandom_range(0, 1);
					end
					2: begin
						out_ready <= ($urandom_range(0, 3) == 0);
					end
					default: begin
						out_ready <= ($urandom_range(0, 7) != 0);
					end
				endcase
				@(posedge clk);
			end
		end
	end

	// Holds the beat until the block takes it; valid stays high on return so
	// that a following beat in the same burst goes out back to back.
	task automatic send_beat(in_beat_t b);
		in_valid <= 1'b1;
		in_data <= b;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic pause_input(int n);
		in_valid <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	function automatic in_beat_t mk_req(logic f, int cnt, int al, int idx);
		in_beat_t b;
		b.func = f;
		b.page_count = cnt;
		b.align_log2 = al;
		b.page_index = idx;
		return b;
	endfunction

	function automatic in_beat_t random_req();
		in_beat_t    b;
		int          pick;
		int          k;
		int unsigned cnt;
		pick = $urandom_range(0, 99);
		b = mk_req(FUNC_ALLOC, 0, $urandom_range(0, 15), $urandom_range(0, 4095));
		if (pick < 45) begin
			// Mostly small grants at modest alignment, now and then a large one.
			case ($urandom_range(0, 9))
				0: cnt = $urandom_range(65, 1024);
				1: cnt = $urandom_range(0, 8191);
				default: cnt = $urandom_range(1, 64);
			endcase
			b.page_count = cnt;
			if ($urandom_range(0, 3) != 0) b.align_log2 = $urandom_range(0, 4);
		end else if (pick < 80 && live_first.size() > 0) begin
			k = $urandom_range(0, live_first.size() - 1);
			b.func = FUNC_FREE;
			b.page_index = live_first[k];
			b.page_count = live_cnt[k];
			live_first.delete(k);
			live_cnt.delete(k);
		end else begin
			// Noise: arbitrary ranges, some out of bounds, some overlapping.
			b.func = FUNC_FREE;
			if ($urandom_range(0, 1)) b.page_count = $urandom_range(0, 8191);
			else b.page_count = $urandom_range(0, 32);
		end
		return b;
	endfunction

	task automatic write_base(logic [31:0] v);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// The first edge lets the checker record the last accepted beat before
	// the pending count is trusted.
	task automatic drain_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (64) @(posedge clk);
	endtask

	initial begin
		logic [31:0] bases [NUM_PHASES];
		in_beat_t    directed [$];
		int          burst;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		in_data <= '0;
		cfg_we <= 1'b0;
		cfg_wdata <= '0;
		hold_req = 1'b0;
		idle_cycles = 0;
		bases[0] = 32'h0000_0000;
		bases[1] = 32'hFFFF_FFFF;
		bases[2] = 32'h0000_3ABC;
		bases[3] = $urandom();
		bases[4] = 32'h8000_0FFF;

		// Field extremes and the documented corner cases: bad counts, a
		// request too large for any level, full-region frees whose length runs
		// past the top level, duplicate frees and saturation of the free count.
		directed.push_back(mk_req(FUNC_ALLOC, 0, 0, 0));
		directed.push_back(mk_req(FUNC_ALLOC, 4097, 0, 4095));
		directed.push_back(mk_req(FUNC_ALLOC, 8191, 15, 0));
		directed.push_back(mk_req(FUNC_ALLOC, 4096, 0, 0));
		directed.push_back(mk_req(FUNC_ALLOC, 1025, 0, 0));
		directed.push_back(mk_req(FUNC_ALLOC, 1024, 0, 0));
		directed.push_back(mk_req(FUNC_ALLOC, 1, 15, 0));
		directed.push_back(mk_req(FUNC_ALLOC, 1, 10, 0));
		directed.push_back(mk_req(FUNC_ALLOC, 3, 2, 0));
		directed.push_back(mk_req(FUNC_ALLOC, 5, 0, 0));
		directed.push_back(mk_req(FUNC_FREE, 0, 0, 0));
		directed.push_back(mk_req(FUNC_FREE, 2, 0, 4095));
		directed.push_back(mk_req(FUNC_FREE, 8191, 15, 4095));
		directed.push_back(mk_req(FUNC_FREE, 1, 0, 4095));
		directed.push_back(mk_req(FUNC_FREE, 1, 0, 4095));
		directed.push_back(mk_req(FUNC_FREE, 4096, 0, 0));
		directed.push_back(mk_req(FUNC_ALLOC, 1024, 10, 0));
		directed.push_back(mk_req(FUNC_ALLOC, 1024, 10, 0));
		directed.push_back(mk_req(FUNC_FREE, 2048, 0, 0));
		directed.push_back(mk_req(FUNC_ALLOC, 512, 9, 0));
		directed.push_back(mk_req(FUNC_FREE, 1, 0, 1));
		directed.push_back(mk_req(FUNC_FREE, 1, 0, 2));
		directed.push_back(mk_req(FUNC_ALLOC, 2, 1, 0));

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			// The base register is written with the block idle, but for the first write, which lands during the clearing pass.
			write_base(bases[ph]);
			if (ph == 0) begin
				foreach (directed[i]) send_beat(directed[i]);
				drain_results();
			end
			// One phase starves the output for a long stretch while the input
			// keeps offering beats.
			if (ph == 2) hold_req = 1'b1;
			burst = 0;
			for (int i = 0; i < RAND_PER_PHASE; i++) begin
				if (burst == 0) begin
					burst = $urandom_range(1, 12);
					if ($urandom_range(0, 2) != 0) pause_input($urandom_range(1, 40));
				end
				send_beat(random_req());
				burst--;
			end
			// Wait for every result so the next phase starts from idle.
			drain_results();
		end

		repeat (200) @(posedge clk);
		if (fail_count == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
